### rtl/core/ise_pkg.sv
// Shared definitions for the integer stack engine: opcodes, status codes,
// interface field widths and default sizes. Depends on nothing.
package ise_pkg;

	// Interface field widths
	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	// Default sizes handed to the top level parameters
	localparam int DEPTH_DEF      = 32;
	localparam int DATA_WIDTH_DEF = 32;

	// Entries in the queue between the front and the back end
	localparam int Q_DEPTH = 2;

	// Opcodes
	localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PRINT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SWAP  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ADD   = 3'd5;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

### rtl/core/ise_ram.sv
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
module ise_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### rtl/core/ise_front.sv
// Front end of the integer stack engine: accepts input transactions, drops
// unused opcodes and sign-extends or cuts the push value to the stack width. Depends on ise_pkg.
module ise_front
	import ise_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [VALUE_W-1:0]    s_tdata,
	input  logic [CMD_W-1:0]      s_tuser,
	output logic                  op_valid,
	input  logic                  op_ready,
	output logic [CMD_W-1:0]      op_cmd,
	output logic [DATA_WIDTH-1:0] op_value
);

	logic                  valid_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [DATA_WIDTH-1:0] value_s1;
	logic                  legal;

	assign s_tready = !valid_s1 || op_ready;
	assign legal    = s_tuser inside {[CMD_PUSH:CMD_ADD]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= legal;
		end else if (op_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// The pushed value is sign-extended, or cut to its low bits when the
	// stack is narrower than the input field.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= s_tuser;
			value_s1 <= DATA_WIDTH'($signed(s_tdata));
		end
	end

	assign op_valid = valid_s1;
	assign op_cmd   = cmd_s1;
	assign op_value = value_s1;

endmodule

### rtl/core/ise_queue.sv
// Short first-in first-out queue between the front and back ends.
// Depends on ise_pkg for its depth.
module ise_queue
	import ise_pkg::*;
#(
	parameter int WIDTH = 35
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int PW = $clog2(Q_DEPTH);
	localparam int NW = $clog2(Q_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [Q_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign in_ready  = count_q != NW'(Q_DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

### rtl/core/ise_back.sv
// Back end of the integer stack engine: executes queued opcodes against the
// stack RAM and the entry count, and owns the output register. Depends on ise_pkg.
module ise_back
	import ise_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	output logic                     q_ready,
	input  logic [CMD_W-1:0]         q_cmd,
	input  logic [DATA_WIDTH-1:0]    q_value,
	output logic                     we,
	output logic [$clog2(DEPTH)-1:0] waddr,
	output logic [DATA_WIDTH-1:0]    wdata,
	output logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [$clog2(DEPTH)-1:0] raddr_b,
	input  logic [DATA_WIDTH-1:0]    rdata_a,
	input  logic [DATA_WIDTH-1:0]    rdata_b,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [VALUE_W-1:0]       m_tdata,
	output logic [STATUS_W-1:0]      m_tuser,
	output logic                     m_tlast
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_PEEK     = 3'd1;
	localparam logic [2:0] S_BIN      = 3'd2;
	localparam logic [2:0] S_SWAP2    = 3'd3;
	localparam logic [2:0] S_PRINT_RD = 3'd4;
	localparam logic [2:0] S_PRINT_EM = 3'd5;

	logic [2:0]            state_q, state_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [AW-1:0]         ptr_q, ptr_d;
	logic                  is_add_q, is_add_d;
	logic [DATA_WIDTH-1:0] hold_q, hold_d;

	logic                  m_tvalid_q;
	logic [VALUE_W-1:0]    m_tdata_q;
	logic [STATUS_W-1:0]   m_tuser_q;
	logic                  m_tlast_q;

	logic                  out_free;
	logic                  emit;
	logic [VALUE_W-1:0]    emit_data;
	logic [STATUS_W-1:0]   emit_status;
	logic                  emit_last;
	logic [AW-1:0]         top_addr;
	logic [AW-1:0]         sec_addr;
	logic                  is_empty;
	logic                  is_full;
	logic                  is_short;

	assign out_free = !m_tvalid_q || m_tready;
	assign top_addr = AW'(cnt_q - CW'(1));
	assign sec_addr = AW'(cnt_q - CW'(2));
	assign is_empty = cnt_q == '0;
	assign is_full  = cnt_q == CW'(DEPTH);
	assign is_short = cnt_q < CW'(2);

	// Port A follows the top of stack while idle, so the top entry is ready
	// in the cycle after an opcode is taken; afterwards it follows the pointer.
	assign raddr_a = (state_q == S_IDLE) ? top_addr : ptr_q;
	assign raddr_b = sec_addr;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		ptr_d       = ptr_q;
		is_add_d    = is_add_q;
		hold_d      = hold_q;
		q_ready     = 1'b0;
		we          = 1'b0;
		waddr       = top_addr;
		wdata       = q_value;
		emit        = 1'b0;
		emit_data   = '0;
		emit_status = ST_OK;
		emit_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (q_valid && out_free) begin
					q_ready  = 1'b1;
					ptr_d    = top_addr;
					is_add_d = q_cmd == CMD_ADD;
					case (q_cmd)
						CMD_PUSH: begin
							if (is_full) begin
								emit        = 1'b1;
								emit_status = ST_FULL;
							end else begin
								we    = 1'b1;
								waddr = AW'(cnt_q);
								wdata = q_value;
								cnt_d = cnt_q + CW'(1);
							end
						end
						CMD_PRINT: begin
							if (!is_empty) begin
								state_d = S_PRINT_EM;
							end
						end
						CMD_PEEK: begin
							if (is_empty) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
							end else begin
								state_d = S_PEEK;
							end
						end
						CMD_POP: begin
							if (is_empty) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
							end else begin
								cnt_d = cnt_q - CW'(1);
							end
						end
						CMD_SWAP, CMD_ADD: begin
							if (is_short) begin
								emit        = 1'b1;
								emit_status = ST_SHORT;
							end else begin
								state_d = S_BIN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_PEEK: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_data = VALUE_W'(rdata_a);
					state_d   = S_IDLE;
				end
			end
			S_BIN: begin
				we = 1'b1;
				if (is_add_q) begin
					waddr   = sec_addr;
					wdata   = rdata_a + rdata_b;
					cnt_d   = cnt_q - CW'(1);
					state_d = S_IDLE;
				end else begin
					waddr   = top_addr;
					wdata   = rdata_b;
					hold_d  = rdata_a;
					state_d = S_SWAP2;
				end
			end
			S_SWAP2: begin
				we      = 1'b1;
				waddr   = sec_addr;
				wdata   = hold_q;
				state_d = S_IDLE;
			end
			S_PRINT_RD: begin
				state_d = S_PRINT_EM;
			end
			S_PRINT_EM: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_data = VALUE_W'(rdata_a);
					emit_last = ptr_q == '0;
					if (ptr_q == '0) begin
						state_d = S_IDLE;
					end else begin
						ptr_d   = ptr_q - AW'(1);
						state_d = S_PRINT_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q    <= ptr_d;
		is_add_q <= is_add_d;
		hold_q   <= hold_d;
		if (emit) begin
			m_tdata_q <= emit_data;
			m_tuser_q <= emit_status;
			m_tlast_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

### rtl/core/integer_stack_engine_core.sv
// Integer stack engine, top level. Each result passes the front-end register, the queue,
// the back-end sequencer and its output register; a peek or print result also waits on a RAM
// read. The back end takes a new opcode only when idle: swap writes its two entries one after
// the other through the single RAM write port, and print emits every stored entry. Reset
// (arst_n low, asynchronous) empties the stack, the queue and the output register; the stack
// RAM itself is not cleared.
// Depends on ise_pkg, ise_front, ise_queue, ise_back and ise_ram.
module integer_stack_engine_core
	import ise_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Slave side: one opcode per transaction.
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [VALUE_W-1:0]  s_tdata,   // [31:0] value
	input  logic [CMD_W-1:0]    s_tuser,   // [2:0] cmd
	// Master side: one result per transaction.
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [VALUE_W-1:0]  m_tdata,   // [31:0] value_res
	output logic [STATUS_W-1:0] m_tuser,   // [1:0] status
	output logic                m_tlast    // last
);

	localparam int AW = $clog2(DEPTH);
	localparam int OW = CMD_W + DATA_WIDTH;

	// The front end registers each opcode and discards the unused codes, so the
	// back end only ever sees the six defined operations.
	logic                  op_valid;
	logic                  op_ready;
	logic [CMD_W-1:0]      op_cmd;
	logic [DATA_WIDTH-1:0] op_value;

	// The queue lets the front keep taking transactions while the back end is
	// busy with a multi-cycle operation or waits on a stalled master side.
	logic                  q_valid;
	logic                  q_ready;
	logic [OW-1:0]         q_data;

	// Stack RAM: entry 0 is the bottom; only entries below the count are used.
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [AW-1:0]         raddr_a;
	logic [AW-1:0]         raddr_b;
	logic [DATA_WIDTH-1:0] rdata_a;
	logic [DATA_WIDTH-1:0] rdata_b;

	ise_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.op_valid(op_valid),
		.op_ready(op_ready),
		.op_cmd  (op_cmd),
		.op_value(op_value)
	);

	ise_queue #(
		.WIDTH(OW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (op_valid),
		.in_ready (op_ready),
		.in_data  ({op_cmd, op_value}),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_data (q_data)
	);

	// The back end runs one operation at a time and owns the output register,
	// so a finished result can wait on the master side while the queue fills.
	ise_back #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_cmd   (q_data[OW-1:DATA_WIDTH]),
		.q_value (q_data[DATA_WIDTH-1:0]),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	ise_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_stack_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

endmodule
